[rtl/vcc_pkg.sv]
// Package with the constants, types and helpers of the vector clock block.
`default_nettype none
package vcc_pkg;

  localparam int MAX_PROCS  = 8;
  localparam int COUNT_BITS = 32;
  localparam int NUM_TS     = 8;
  localparam int FIELD_BITS = 32;
  localparam int IDX_BITS   = 3;
  localparam int GSIZE_BITS = 4;
  localparam int WIDE_BITS  = (COUNT_BITS > FIELD_BITS) ? COUNT_BITS : FIELD_BITS;

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef cnt_t [MAX_PROCS-1:0] vec_t;
  typedef logic [FIELD_BITS-1:0] field_t;
  typedef field_t [NUM_TS-1:0] ts_vec_t;

  localparam cnt_t CNT_MAX = '1;

  typedef enum logic {
    CMD_SEND = 1'b0,
    CMD_RECV = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_SENT      = 2'd0,
    ST_DELIVERED = 2'd1,
    ST_HELD      = 2'd2,
    ST_INVALID   = 2'd3
  } status_t;

  typedef enum logic {
    REG_SELF_INDEX = 1'b0,
    REG_GROUP_SIZE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [IDX_BITS-1:0]   self_index;
    logic [GSIZE_BITS-1:0] group_size;
  } cfg_t;

  function automatic cnt_t sat_count(input field_t t);
    logic [WIDE_BITS-1:0] tw;
    tw = WIDE_BITS'(t);
    if (tw > WIDE_BITS'(CNT_MAX)) begin
      return CNT_MAX;
    end
    return cnt_t'(tw);
  endfunction

  function automatic field_t to_field(input cnt_t c);
    logic [WIDE_BITS-1:0] cw;
    cw = WIDE_BITS'(c);
    return cw[FIELD_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

[rtl/vcc_core.sv]
// Combinational send, delivery check and merge for the local vector clock.
`default_nettype none
module vcc_core
  import vcc_pkg::*;
(
  input  cmd_t                cmd,
  input  logic [IDX_BITS-1:0] sender,
  input  ts_vec_t             ts,
  input  vec_t                clock_cur,
  input  cfg_t                cfg,
  output status_t             status,
  output vec_t                clock_next
);

  logic [GSIZE_BITS-1:0] n;
  logic [MAX_PROCS-1:0]  in_use;
  logic [MAX_PROCS-1:0]  ok;
  vec_t                  ts_sat;
  logic                  sender_ok;
  logic                  self_ok;

  always_comb begin
    if (cfg.group_size == '0) begin
      n = GSIZE_BITS'(1);
    end else if (cfg.group_size > GSIZE_BITS'(MAX_PROCS)) begin
      n = GSIZE_BITS'(MAX_PROCS);
    end else begin
      n = cfg.group_size;
    end
    sender_ok = GSIZE_BITS'(sender) < n;
    self_ok   = GSIZE_BITS'(cfg.self_index) < n;
    for (int i = 0; i < MAX_PROCS; i++) begin
      in_use[i] = GSIZE_BITS'(i) < n;
      ts_sat[i] = sat_count(ts[i]);
      if (!in_use[i]) begin
        ok[i] = 1'b1;
      end else if (IDX_BITS'(i) == sender) begin
        ok[i] = (clock_cur[i] != CNT_MAX) && (ts_sat[i] == clock_cur[i] + cnt_t'(1));
      end else begin
        ok[i] = ts_sat[i] <= clock_cur[i];
      end
    end

    clock_next = clock_cur;
    if (cmd == CMD_SEND) begin
      status = ST_SENT;
      for (int i = 0; i < MAX_PROCS; i++) begin
        if (self_ok && IDX_BITS'(i) == cfg.self_index && clock_cur[i] != CNT_MAX) begin
          clock_next[i] = clock_cur[i] + cnt_t'(1);
        end
      end
    end else if (!sender_ok) begin
      status = ST_INVALID;
    end else if (&ok) begin
      status = ST_DELIVERED;
      for (int i = 0; i < MAX_PROCS; i++) begin
        if (in_use[i] && ts_sat[i] > clock_cur[i]) begin
          clock_next[i] = ts_sat[i];
        end
      end
    end else begin
      status = ST_HELD;
    end
  end

endmodule
`default_nettype wire

[rtl/vector_clock_causal_delivery_top.sv]
// Top level of the vector clock causal delivery block.
// Items pass from the input register to the result register. Throughput: one item
// per cycle while the result is not stalled; the clock update is a single pass
// through the comparators and maxima between the input and the result register.
// Reset clears the local clock, the valid flags, self_index to 0 and group_size to 8.
`default_nettype none
module vector_clock_causal_delivery_top
  import vcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic                  cmd,
  input  logic [IDX_BITS-1:0]   sender,
  input  logic [FIELD_BITS-1:0] ts0,
  input  logic [FIELD_BITS-1:0] ts1,
  input  logic [FIELD_BITS-1:0] ts2,
  input  logic [FIELD_BITS-1:0] ts3,
  input  logic [FIELD_BITS-1:0] ts4,
  input  logic [FIELD_BITS-1:0] ts5,
  input  logic [FIELD_BITS-1:0] ts6,
  input  logic [FIELD_BITS-1:0] ts7,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic [1:0]            status,
  output logic [FIELD_BITS-1:0] clk0,
  output logic [FIELD_BITS-1:0] clk1,
  output logic [FIELD_BITS-1:0] clk2,
  output logic [FIELD_BITS-1:0] clk3,
  output logic [FIELD_BITS-1:0] clk4,
  output logic [FIELD_BITS-1:0] clk5,
  output logic [FIELD_BITS-1:0] clk6,
  output logic [FIELD_BITS-1:0] clk7
);

  cfg_t                cfg;
  vec_t                local_clock;
  vec_t                clock_next;
  vec_t                res_clk;
  status_t             res_status;
  status_t             core_status;
  logic                s1_valid;
  cmd_t                s1_cmd;
  logic [IDX_BITS-1:0] s1_sender;
  ts_vec_t             s1_ts;
  ts_vec_t             clk_field;
  reg_idx_t            reg_sel;
  logic                adv;
  logic                take;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);

  always_comb begin
    unique case (reg_sel)
      REG_SELF_INDEX: prdata = 32'(cfg.self_index);
      REG_GROUP_SIZE: prdata = 32'(cfg.group_size);
      default:        prdata = '0;
    endcase
  end

  assign adv       = !rsp_valid || !rsp_stall;
  assign req_stall = s1_valid && !adv;
  assign take      = req_valid && !req_stall;

  vcc_core u_core (
    .cmd        (s1_cmd),
    .sender     (s1_sender),
    .ts         (s1_ts),
    .clock_cur  (local_clock),
    .cfg        (cfg),
    .status     (core_status),
    .clock_next (clock_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.self_index <= '0;
      cfg.group_size <= GSIZE_BITS'(MAX_PROCS);
      local_clock    <= '0;
      s1_valid       <= 1'b0;
      rsp_valid      <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        unique case (reg_sel)
          REG_SELF_INDEX: cfg.self_index <= pwdata[IDX_BITS-1:0];
          REG_GROUP_SIZE: cfg.group_size <= pwdata[GSIZE_BITS-1:0];
          default: ;
        endcase
      end
      if (!req_stall) begin
        s1_valid <= req_valid;
      end
      if (adv) begin
        rsp_valid <= s1_valid;
        if (s1_valid) begin
          local_clock <= clock_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_cmd    <= cmd_t'(cmd);
      s1_sender <= sender;
      s1_ts     <= {ts7, ts6, ts5, ts4, ts3, ts2, ts1, ts0};
    end
    if (adv && s1_valid) begin
      res_status <= core_status;
      res_clk    <= clock_next;
    end
  end

  for (genvar j = 0; j < NUM_TS; j++) begin : g_field
    if (j < MAX_PROCS) begin : g_used
      assign clk_field[j] = to_field(res_clk[j]);
    end else begin : g_zero
      assign clk_field[j] = '0;
    end
  end

  assign status = res_status;
  assign clk0   = clk_field[0];
  assign clk1   = clk_field[1];
  assign clk2   = clk_field[2];
  assign clk3   = clk_field[3];
  assign clk4   = clk_field[4];
  assign clk5   = clk_field[5];
  assign clk6   = clk_field[6];
  assign clk7   = clk_field[7];

`ifndef SYNTHESIS
  a_clock_idle: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |=> $stable(local_clock))
    else $error("Local clock changed with no item in the input register.");

  a_result_matches_clock: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> res_clk == local_clock)
    else $error("Pending result does not match the local clock.");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> s1_valid && rsp_valid && rsp_stall)
    else $error("Input stalled without a blocked result.");
`endif

endmodule
`default_nettype wire
